// ===== sv/clp_pkg.sv =====
// shared types and constants of the content-length list parser
`timescale 1ns / 1ps

package clp_pkg;

    localparam int unsigned CLP_MAX_VALUE_LEN = 65535;

    localparam logic [1:0] STATUS_FIRST = 2'd0;
    localparam logic [1:0] STATUS_DUP   = 2'd1;
    localparam logic [1:0] STATUS_FAIL  = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // largest accumulator that can still be multiplied by ten
    localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       value_end;
        logic       message_start;
    } clp_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] body_length;
        logic        word_found;
        logic [15:0] word_start;
        logic [15:0] word_length;
    } clp_result_t;

    typedef struct packed {
        logic      valid;
        clp_item_t item;
    } clp_stage_t;

endpackage

// ===== sv/clp_item_if.sv =====
// input item channel
`timescale 1ns / 1ps

interface clp_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       value_end;
    logic       message_start;

    modport source (
        output valid, data_byte, byte_present, value_end, message_start,
        input  ready
    );

    modport sink (
        input  valid, data_byte, byte_present, value_end, message_start,
        output ready
    );

    modport mon (
        input valid, ready, data_byte, byte_present, value_end, message_start
    );
endinterface

// ===== sv/clp_result_if.sv =====
// result item channel
`timescale 1ns / 1ps

interface clp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] body_length;
    logic        word_found;
    logic [15:0] word_start;
    logic [15:0] word_length;

    modport source (
        output valid, status, body_length, word_found, word_start, word_length,
        input  ready
    );

    modport sink (
        input  valid, status, body_length, word_found, word_start, word_length,
        output ready
    );

    modport mon (
        input valid, ready, status, body_length, word_found, word_start, word_length
    );
endinterface

// ===== sv/clp_in_stage.sv =====
// input register stage
`timescale 1ns / 1ps

module clp_in_stage
    import clp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    clp_item_if.sink   item,
    input  logic       can_advance,
    output clp_stage_t stage,
    output logic       fire
);

    logic      valid_reg;
    logic      valid_next;
    clp_item_t item_reg;
    logic      take;

    assign fire       = valid_reg && can_advance;
    assign item.ready = !valid_reg || can_advance;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte     <= item.data_byte;
            item_reg.byte_present  <= item.byte_present;
            item_reg.value_end     <= item.value_end;
            item_reg.message_start <= item.message_start;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ===== sv/clp_parse_core.sv =====
// parser state and per-byte next-state logic
`timescale 1ns / 1ps

module clp_parse_core
    import clp_pkg::*;
#(
    parameter int unsigned MAX_VALUE_LEN = CLP_MAX_VALUE_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  clp_item_t   item,
    output clp_result_t result
);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGIT,
        PH_TRAIL,
        PH_FAIL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        length_seen_reg, length_seen_next;
    logic [63:0] stored_length_reg, stored_length_next;
    logic        header_had_length_reg, header_had_length_next;
    logic [63:0] accumulator_reg, accumulator_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] current_start_reg, current_start_next;
    logic [15:0] current_length_reg, current_length_next;
    logic [15:0] kept_start_reg, kept_start_next;
    logic [15:0] kept_length_reg, kept_length_next;
    logic        kept_valid_reg, kept_valid_next;

    logic [7:0]  digit_val;
    logic        is_digit;
    logic        is_blank;
    logic        is_comma;
    logic        pos_full;
    logic [63:0] times_ten;
    logic [64:0] digit_sum;
    logic        overflow;
    logic        comma_hit;
    logic        finish;
    logic        match_ok;

    assign digit_val = item.data_byte - CHAR_ZERO;
    assign is_digit  = digit_val <= 8'd9;
    assign is_blank  = (item.data_byte == CHAR_SPACE) || (item.data_byte == CHAR_TAB)
                    || (item.data_byte == CHAR_CR) || (item.data_byte == CHAR_LF);
    assign is_comma  = item.data_byte == CHAR_COMMA;
    assign pos_full  = (32'(byte_position_reg) >= MAX_VALUE_LEN)
                    || (byte_position_reg == 16'hFFFF);

    // multiply by ten as shift-add, then add the digit with carry out
    assign times_ten = {accumulator_reg[60:0], 3'b000} + {accumulator_reg[62:0], 1'b0};
    assign digit_sum = {1'b0, times_ten} + {57'd0, digit_val};
    assign overflow  = (accumulator_reg > ACC_LIMIT) || digit_sum[64];

    always_comb
    begin
        length_seen_next       = item.message_start ? 1'b0 : length_seen_reg;
        header_had_length_next = header_had_length_reg;
        if ((item.byte_present || item.value_end) && (byte_position_reg == 16'd0)
            && (phase_reg == PH_LEAD))
        begin
            header_had_length_next = length_seen_next;
        end

        phase_next          = phase_reg;
        stored_length_next  = stored_length_reg;
        accumulator_next    = accumulator_reg;
        byte_position_next  = byte_position_reg;
        current_start_next  = current_start_reg;
        current_length_next = current_length_reg;
        kept_start_next     = kept_start_reg;
        kept_length_next    = kept_length_reg;
        kept_valid_next     = kept_valid_reg;
        comma_hit           = 1'b0;

        if (item.byte_present)
        begin
            if (pos_full)
            begin
                phase_next = PH_FAIL;
            end
            else
            begin
                case (phase_reg)
                    PH_LEAD:
                    begin
                        if (is_blank)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else if (is_digit)
                        begin
                            accumulator_next    = {56'd0, digit_val};
                            current_start_next  = byte_position_reg;
                            current_length_next = 16'd1;
                            phase_next          = PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (is_digit)
                        begin
                            if (overflow)
                            begin
                                phase_next = PH_FAIL;
                            end
                            else
                            begin
                                accumulator_next    = digit_sum[63:0];
                                current_length_next = current_length_reg + 16'd1;
                            end
                        end
                        else if (is_blank)
                        begin
                            phase_next = PH_TRAIL;
                        end
                        else if (is_comma)
                        begin
                            comma_hit = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_TRAIL:
                    begin
                        if (is_blank)
                        begin
                            phase_next = PH_TRAIL;
                        end
                        else if (is_comma)
                        begin
                            comma_hit = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FAIL;
                    end
                endcase
                byte_position_next = byte_position_reg + 16'd1;
            end
        end

        // a comma and a value end close at most one number per item
        finish = comma_hit
              || (item.value_end && ((phase_next == PH_DIGIT) || (phase_next == PH_TRAIL)));
        match_ok = !(length_seen_next && (accumulator_next != stored_length_reg));

        if (finish)
        begin
            if (match_ok)
            begin
                length_seen_next   = 1'b1;
                stored_length_next = accumulator_next;
                kept_start_next    = current_start_next;
                kept_length_next   = current_length_next;
                kept_valid_next    = 1'b1;
                phase_next         = PH_LEAD;
            end
            else
            begin
                phase_next = PH_FAIL;
            end
        end

        if (phase_next == PH_FAIL)
        begin
            result.status = STATUS_FAIL;
        end
        else if (header_had_length_next)
        begin
            result.status = STATUS_DUP;
        end
        else
        begin
            result.status = STATUS_FIRST;
        end
        result.body_length = stored_length_next;
        result.word_found  = kept_valid_next;
        result.word_start  = kept_start_next;
        result.word_length = kept_length_next;

        if (item.value_end)
        begin
            phase_next          = PH_LEAD;
            accumulator_next    = 64'd0;
            byte_position_next  = 16'd0;
            current_start_next  = 16'd0;
            current_length_next = 16'd0;
            kept_start_next     = 16'd0;
            kept_length_next    = 16'd0;
            kept_valid_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_LEAD;
            length_seen_reg       <= 1'b0;
            stored_length_reg     <= 64'd0;
            header_had_length_reg <= 1'b0;
            accumulator_reg       <= 64'd0;
            byte_position_reg     <= 16'd0;
            current_start_reg     <= 16'd0;
            current_length_reg    <= 16'd0;
            kept_start_reg        <= 16'd0;
            kept_length_reg       <= 16'd0;
            kept_valid_reg        <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg             <= phase_next;
            length_seen_reg       <= length_seen_next;
            stored_length_reg     <= stored_length_next;
            header_had_length_reg <= header_had_length_next;
            accumulator_reg       <= accumulator_next;
            byte_position_reg     <= byte_position_next;
            current_start_reg     <= current_start_next;
            current_length_reg    <= current_length_next;
            kept_start_reg        <= kept_start_next;
            kept_length_reg       <= kept_length_next;
            kept_valid_reg        <= kept_valid_next;
        end
    end

endmodule

// ===== sv/clp_out_stage.sv =====
// result register stage
`timescale 1ns / 1ps

module clp_out_stage
    import clp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic         value_end,
    input  clp_result_t  result_in,
    output logic         can_advance,
    clp_result_if.source result
);

    logic        valid_reg;
    logic        valid_next;
    clp_result_t data_reg;

    assign can_advance = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = value_end;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && value_end)
        begin
            data_reg <= result_in;
        end
    end

    assign result.valid       = valid_reg;
    assign result.status      = data_reg.status;
    assign result.body_length = data_reg.body_length;
    assign result.word_found  = data_reg.word_found;
    assign result.word_start  = data_reg.word_start;
    assign result.word_length = data_reg.word_length;

endmodule

// ===== sv/content_length_list_parser.sv =====
// top level of the content-length list parser
// a result is loaded into the result register after the input register takes the item that ends the value
// throughput: 1 item per cycle; the input register feeds the parser state update
// and the result register in the same cycle, stalling only while a result waits
// reset: rst_n low clears the parse state, the stored length and both stage valids
`timescale 1ns / 1ps

module content_length_list_parser
    import clp_pkg::*;
#(
    parameter int unsigned MAX_VALUE_LEN = CLP_MAX_VALUE_LEN
) (
    input  logic         clk,
    input  logic         rst_n,
    clp_item_if.sink     item,
    clp_result_if.source result
);

    clp_stage_t  stage;
    logic        fire;
    logic        can_advance;
    clp_result_t core_result;

    clp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .can_advance (can_advance),
        .stage       (stage),
        .fire        (fire)
    );

    clp_parse_core #(
        .MAX_VALUE_LEN (MAX_VALUE_LEN)
    ) u_parse_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (stage.item),
        .result (core_result)
    );

    clp_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .value_end   (stage.item.value_end),
        .result_in   (core_result),
        .can_advance (can_advance),
        .result      (result)
    );

endmodule

// ===== sv/clp_checker.sv =====
// port-level assertions for the content-length list parser
`timescale 1ns / 1ps

module clp_checker
    import clp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        item_value_end,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  result_status,
    input logic [63:0] body_length,
    input logic        word_found,
    input logic [15:0] word_start,
    input logic [15:0] word_length
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(body_length)
            && $stable(result_status) && $stable(word_start)
            && $stable(word_length) && $stable(word_found))
        else $error("result payload changed while stalled");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && item_value_end, 2))
        else $error("result without a value end item two cycles earlier");

    a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_status <= STATUS_FAIL)
            && (word_found || ((word_start == 16'd0)
            && (word_length == 16'd0))))
        else $error("inconsistent result fields");

endmodule

bind content_length_list_parser clp_checker u_clp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_value_end (item.value_end),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_status  (result.status),
    .body_length    (result.body_length),
    .word_found     (result.word_found),
    .word_start     (result.word_start),
    .word_length    (result.word_length)
);

// ===== tb/testbench.sv =====
// testbench of the content-length list parser: queued header bytes checked against a local parser
`timescale 1ns / 1ps

module testbench;
    import clp_pkg::*;

    typedef enum logic [1:0] {SCAN_LEAD, SCAN_DIGITS, SCAN_TRAIL, SCAN_BROKEN} scan_t;

    typedef struct {
        clp_item_t   item;
        int unsigned gap;
    } header_byte_t;

    localparam int RANDOM_ITEMS = 1050;

    logic clk = 1'b0;
    logic rst_n;

    clp_item_if   item_bus ();
    clp_result_if result_bus ();

    content_length_list_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    always #1 clk = ~clk;

    header_byte_t header_stream[$];
    clp_result_t  expected_verdicts[$];
    int unsigned  mismatches = 0;
    int unsigned  send_calm = 0;
    int unsigned  recv_calm = 0;
    int unsigned  send_hold = 0;
    int unsigned  recv_stall = 0;
    bit           send_armed = 1'b0;
    header_byte_t next_byte;
    clp_item_t    taken_item;
    clp_result_t  want;

    // local copy of the parser state
    scan_t       scan = SCAN_LEAD;
    bit          len_known = 1'b0;
    logic [63:0] len_value = '0;
    bit          had_len = 1'b0;
    logic [63:0] acc = '0;
    logic [15:0] pos = '0;
    logic [15:0] num_start = '0;
    logic [15:0] num_digits = '0;
    logic [15:0] keep_start = '0;
    logic [15:0] keep_digits = '0;
    bit          keep_valid = 1'b0;

    function automatic int unsigned pick_wait(inout int unsigned calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
    endfunction

    function automatic bit close_number();
        if (len_known && acc != len_value)
            return 1'b0;
        len_known   = 1'b1;
        len_value   = acc;
        keep_start  = num_start;
        keep_digits = num_digits;
        keep_valid  = 1'b1;
        return 1'b1;
    endfunction

    task automatic predict_item(input clp_item_t it);
        logic [7:0]  d;
        logic [64:0] sum;
        clp_result_t r;
        if (it.message_start)
            len_known = 1'b0;
        if ((it.byte_present || it.value_end) && pos == 16'd0 && scan == SCAN_LEAD)
            had_len = len_known;
        if (it.byte_present)
        begin
            d = it.data_byte - CHAR_ZERO;
            if (32'(pos) >= CLP_MAX_VALUE_LEN || pos == 16'hFFFF)
            begin
                scan = SCAN_BROKEN;
            end
            else
            begin
                case (scan)
                    SCAN_LEAD:
                    begin
                        if (!is_blank(it.data_byte))
                        begin
                            if (d <= 8'd9)
                            begin
                                acc        = {56'd0, d};
                                num_start  = pos;
                                num_digits = 16'd1;
                                scan       = SCAN_DIGITS;
                            end
                            else
                                scan = SCAN_BROKEN;
                        end
                    end
                    SCAN_DIGITS:
                    begin
                        if (d <= 8'd9)
                        begin
                            if (acc > ACC_LIMIT)
                                scan = SCAN_BROKEN;
                            else
                            begin
                                sum = {1'b0, acc} * 65'd10 + {57'd0, d};
                                if (sum[64])
                                    scan = SCAN_BROKEN;
                                else
                                begin
                                    acc        = sum[63:0];
                                    num_digits = num_digits + 16'd1;
                                end
                            end
                        end
                        else if (is_blank(it.data_byte))
                            scan = SCAN_TRAIL;
                        else if (it.data_byte == CHAR_COMMA)
                            scan = close_number() ? SCAN_LEAD : SCAN_BROKEN;
                        else
                            scan = SCAN_BROKEN;
                    end
                    SCAN_TRAIL:
                    begin
                        if (!is_blank(it.data_byte))
                        begin
                            if (it.data_byte == CHAR_COMMA)
                                scan = close_number() ? SCAN_LEAD : SCAN_BROKEN;
                            else
                                scan = SCAN_BROKEN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                pos = pos + 16'd1;
            end
        end
        if (it.value_end)
        begin
            if (scan == SCAN_DIGITS || scan == SCAN_TRAIL)
                scan = close_number() ? SCAN_LEAD : SCAN_BROKEN;
            r.status      = (scan == SCAN_BROKEN) ? STATUS_FAIL
                          : (had_len ? STATUS_DUP : STATUS_FIRST);
            r.body_length = len_value;
            r.word_found  = keep_valid;
            r.word_start  = keep_start;
            r.word_length = keep_digits;
            expected_verdicts.push_back(r);
            scan        = SCAN_LEAD;
            acc         = '0;
            pos         = '0;
            num_start   = '0;
            num_digits  = '0;
            keep_start  = '0;
            keep_digits = '0;
            keep_valid  = 1'b0;
        end
    endtask

    task automatic push_item(input logic [7:0] c, input bit present, input bit last,
                             input bit fresh, input bit hurry);
        header_byte_t e;
        e.item.data_byte     = c;
        e.item.byte_present  = present;
        e.item.value_end     = last;
        e.item.message_start = fresh;
        e.gap                = hurry ? 0 : pick_wait(send_calm);
        header_stream.push_back(e);
    endtask

    task automatic add_value(input string body, input bit fresh, input bit end_alone);
        int i;
        for (i = 0; i < body.len(); i++)
        begin
            if ($urandom_range(0, 15) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, $urandom_range(0, 3) == 0, 1'b0);
            push_item(body[i], 1'b1, !end_alone && i == body.len() - 1, fresh && i == 0, 1'b0);
        end
        if (end_alone || body.len() == 0)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, fresh && body.len() == 0, 1'b0);
    endtask

    function automatic string blank_run(input int unsigned n);
        string      s;
        logic [7:0] c;
        s = "";
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0: c = CHAR_SPACE;
                1: c = CHAR_TAB;
                2: c = CHAR_CR;
                default: c = CHAR_LF;
            endcase
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
            send_armed = 1'b0;
        end
        else if (!item_bus.valid || item_bus.ready)
        begin
            if (header_stream.size() == 0)
                item_bus.valid <= 1'b0;
            else
            begin
                if (!send_armed)
                begin
                    send_hold  = header_stream[0].gap;
                    send_armed = 1'b1;
                end
                if (send_hold > 0)
                begin
                    item_bus.valid <= 1'b0;
                    send_hold--;
                end
                else
                begin
                    next_byte = header_stream.pop_front();
                    item_bus.data_byte     <= next_byte.item.data_byte;
                    item_bus.byte_present  <= next_byte.item.byte_present;
                    item_bus.value_end     <= next_byte.item.value_end;
                    item_bus.message_start <= next_byte.item.message_start;
                    item_bus.valid         <= 1'b1;
                    send_armed = 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
                recv_stall = pick_wait(recv_calm);
            if (recv_stall > 0)
            begin
                result_bus.ready <= 1'b0;
                recv_stall--;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                taken_item = {item_bus.data_byte, item_bus.byte_present,
                              item_bus.value_end, item_bus.message_start};
                predict_item(taken_item);
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result with none pending: status %0d body_length %0d",
                           result_bus.status, result_bus.body_length);
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result_bus.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result_bus.status);
                        mismatches++;
                    end
                    if (result_bus.body_length !== want.body_length)
                    begin
                        $error("body_length: expected %0d, actual %0d",
                               want.body_length, result_bus.body_length);
                        mismatches++;
                    end
                    if (result_bus.word_found !== want.word_found)
                    begin
                        $error("word_found: expected %0d, actual %0d",
                               want.word_found, result_bus.word_found);
                        mismatches++;
                    end
                    if (result_bus.word_start !== want.word_start)
                    begin
                        $error("word_start: expected %0d, actual %0d",
                               want.word_start, result_bus.word_start);
                        mismatches++;
                    end
                    if (result_bus.word_length !== want.word_length)
                    begin
                        $error("word_length: expected %0d, actual %0d",
                               want.word_length, result_bus.word_length);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        string       body;
        logic [63:0] last_num;
        logic [7:0]  c;
        int          base;
        int          n;
        int          j;
        int          k;
        bit          fresh;

        rst_n                  = 1'b0;
        item_bus.valid         = 1'b0;
        item_bus.data_byte     = 8'd0;
        item_bus.byte_present  = 1'b0;
        item_bus.value_end     = 1'b0;
        item_bus.message_start = 1'b0;
        result_bus.ready       = 1'b0;

        // directed values
        push_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
        add_value("0", 1'b0, 1'b0);
        add_value("0,", 1'b0, 1'b0);
        add_value("9", 1'b0, 1'b0);
        add_value(",1", 1'b1, 1'b0);
        add_value("5,,", 1'b0, 1'b0);
        add_value("\t", 1'b0, 1'b1);
        add_value("x", 1'b0, 1'b0);
        // message start in the middle of a value
        push_item(CHAR_ZERO + 8'd5, 1'b1, 1'b0, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        add_value(" 3\r\n", 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);

        // random values
        base     = header_stream.size();
        last_num = '0;
        while (header_stream.size() - base < RANDOM_ITEMS)
        begin
            k     = $urandom_range(0, 9);
            fresh = $urandom_range(0, 2) == 0;
            if (k <= 6)
            begin
                n    = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
                body = blank_run($urandom_range(0, 1));
                for (j = 0; j < n; j++)
                begin
                    body = {body, blank_run($urandom_range(0, 2))};
                    case ($urandom_range(0, 9))
                        4, 5: last_num = 64'($urandom_range(0, 999));
                        6: last_num = {$urandom, $urandom};
                        7: last_num = '1;
                        8: last_num = ACC_LIMIT * 64'd10 + 64'($urandom_range(0, 5));
                        9: body = {body, "0"};
                        default:
                        begin
                        end
                    endcase
                    body = $sformatf("%s%0d%s", body, last_num, blank_run($urandom_range(0, 2)));
                    if (j < n - 1 || $urandom_range(0, 5) == 0)
                        body = {body, ","};
                end
                add_value(body, fresh, $urandom_range(0, 2) == 0);
            end
            else if (k == 7)
            begin
                case ($urandom_range(0, 2))
                    0: body = $sformatf("%0d%0d", ACC_LIMIT, $urandom_range(6, 9));
                    1: body = $sformatf("%0d%0d", ACC_LIMIT + 64'($urandom_range(1, 99)),
                                        $urandom_range(0, 9));
                    default:
                    begin
                        body = $sformatf("%0d", $urandom_range(1, 9));
                        repeat ($urandom_range(19, 21))
                            body = $sformatf("%s%0d", body, $urandom_range(0, 9));
                    end
                endcase
                add_value(body, fresh, $urandom_range(0, 1) == 0);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (j = 0; j < n; j++)
                begin
                    case ($urandom_range(0, 3))
                        0: c = 8'($urandom_range(0, 255));
                        1: c = CHAR_ZERO + 8'($urandom_range(0, 9));
                        2: c = CHAR_COMMA;
                        default: c = CHAR_SPACE;
                    endcase
                    push_item(c, 1'b1, j == n - 1, fresh && j == 0, 1'b0);
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (header_stream.size() != 0 || item_bus.valid)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("PASS content_length_list_parser");
        else
            $display("FAIL content_length_list_parser");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL content_length_list_parser");
        $finish;
    end

endmodule
